### src/tfrm_pkg.sv
// Shared types, codes and constants for the TFTP reply matcher.
// Used by the config register file, the core and the top level.
`default_nettype none

package tfrm_pkg;

  // Wait timer width.
  localparam int TIMER_WIDTH = 32;

  // Widths of the configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  // Largest timer value, held in 64 bits so it can be compared with a load value.
  localparam logic [63:0] TIMER_MAX64 = (TIMER_WIDTH >= 64) ? {64{1'b1}} :
                                        ((64'd1 << TIMER_WIDTH) - 64'd1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RETRIES   = 2'd0,
    REG_TIMEOUT_TICKS = 2'd1,
    REG_BLOCK_SIZE    = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [7:0]  MAX_RETRIES_RST   = 8'd5;
  localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000000;
  localparam logic [15:0] BLOCK_SIZE_RST    = 16'd512;

  // Input commands.
  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_RECV      = 3'd2,
    CMD_SEND_FAIL = 3'd3,
    CMD_RECV_FAIL = 3'd4,
    CMD_WAIT_ERR  = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_WAIT     = 3'd0,
    ST_OK       = 3'd1,
    ST_RETX     = 3'd2,
    ST_GAVE_UP  = 3'd3,
    ST_PEER_ERR = 3'd4,
    ST_NO_CONN  = 3'd5,
    ST_SEND_ERR = 3'd6,
    ST_WAIT_ERR = 3'd7
  } status_t;

  // TFTP opcodes and the error code taken as success.
  localparam logic [15:0] OP_RRQ          = 16'd1;
  localparam logic [15:0] OP_WRQ          = 16'd2;
  localparam logic [15:0] OP_DATA         = 16'd3;
  localparam logic [15:0] OP_ACK          = 16'd4;
  localparam logic [15:0] OP_ERROR        = 16'd5;
  localparam logic [15:0] OP_OACK         = 16'd6;
  localparam logic [15:0] ERR_UNKNOWN_TID = 16'd5;

  // Header overhead added to the block size for the length check.
  localparam logic [16:0] HDR_BYTES = 17'd4;

  // Saturation value of the retry count.
  localparam logic [7:0] RETRY_MAX = 8'hFF;

  // One input item.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] sent_opcode;
    logic [15:0] sent_block;
    logic        last_packet;
    logic [15:0] recv_length;
    logic [15:0] recv_opcode;
    logic [15:0] recv_word;
    logic        conn_reset;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] retries_used;
  } result_t;

  // Configuration seen by the core.
  typedef struct packed {
    logic [7:0]  max_retries;
    logic [31:0] timeout_ticks;
    logic [15:0] block_size;
  } cfg_t;

endpackage

`default_nettype wire

### src/tfrm_if.sv
// Valid/ready channel interfaces for the TFTP reply matcher.
// Depends on nothing; payload widths follow the item and result fields.
`default_nettype none

// Input channel: one event or received packet header per transfer.
interface tfrm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] sent_opcode;
  logic [15:0] sent_block;
  logic        last_packet;
  logic [15:0] recv_length;
  logic [15:0] recv_opcode;
  logic [15:0] recv_word;
  logic        conn_reset;

  modport source (
    output valid, cmd, sent_opcode, sent_block, last_packet,
           recv_length, recv_opcode, recv_word, conn_reset,
    input  ready
  );
  modport sink (
    input  valid, cmd, sent_opcode, sent_block, last_packet,
           recv_length, recv_opcode, recv_word, conn_reset,
    output ready
  );
endinterface

// Result channel: one status per transfer.
interface tfrm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] retries_used;

  modport source (output valid, status, retries_used, input ready);
  modport sink   (input valid, status, retries_used, output ready);
endinterface

`default_nettype wire

### src/tfrm_cfg.sv
// Configuration register file of the TFTP reply matcher.
// Depends on tfrm_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module tfrm_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tfrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tfrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tfrm_pkg::cfg_t                     cfg
);

  logic [7:0]  max_retries_r,   max_retries_nxt;
  logic [31:0] timeout_ticks_r, timeout_ticks_nxt;
  logic [15:0] block_size_r,    block_size_nxt;

  // Write decode; an index past the last register is dropped.
  always_comb begin
    max_retries_nxt   = max_retries_r;
    timeout_ticks_nxt = timeout_ticks_r;
    block_size_nxt    = block_size_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tfrm_pkg::REG_MAX_RETRIES:   max_retries_nxt   = cfg_wdata[7:0];
        tfrm_pkg::REG_TIMEOUT_TICKS: timeout_ticks_nxt = cfg_wdata[31:0];
        tfrm_pkg::REG_BLOCK_SIZE:    block_size_nxt    = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Register storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r   <= tfrm_pkg::MAX_RETRIES_RST;
      timeout_ticks_r <= tfrm_pkg::TIMEOUT_TICKS_RST;
      block_size_r    <= tfrm_pkg::BLOCK_SIZE_RST;
    end else begin
      max_retries_r   <= max_retries_nxt;
      timeout_ticks_r <= timeout_ticks_nxt;
      block_size_r    <= block_size_nxt;
    end
  end

  assign cfg.max_retries   = max_retries_r;
  assign cfg.timeout_ticks = timeout_ticks_r;
  assign cfg.block_size    = block_size_r;

endmodule

`default_nettype wire

### src/tfrm_core.sv
// Exchange state and combinational evaluation of one item of the reply matcher.
// Depends on tfrm_pkg for item, result and config types and the TFTP codes.
`default_nettype none

module tfrm_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        advance,
  input  wire tfrm_pkg::item_t item,
  input  wire tfrm_pkg::cfg_t  cfg,
  output tfrm_pkg::result_t result
);

  logic                 awaiting_r,  awaiting_nxt;
  logic [15:0]          held_op_r,   held_op_nxt;
  logic [15:0]          held_blk_r,  held_blk_nxt;
  logic [7:0]           retry_r,     retry_nxt;
  tfrm_pkg::timer_t     timer_r,     timer_nxt;

  tfrm_pkg::timer_t     load_val;
  logic                 too_big;
  logic                 oversize;
  logic                 reply_ok;
  logic [15:0]          next_blk;
  logic [7:0]           retry_inc;
  tfrm_pkg::status_t    status;

  // Timer load value, saturated to what the timer can hold.
  assign too_big  = {32'd0, cfg.timeout_ticks} > tfrm_pkg::TIMER_MAX64;
  assign load_val = too_big ? '1 : tfrm_pkg::timer_t'(cfg.timeout_ticks);

  // Length check against block size plus the header.
  assign oversize = {1'b0, item.recv_length} > ({1'b0, cfg.block_size} + tfrm_pkg::HDR_BYTES);

  // Expected DATA block after an ACK wraps at 65536.
  assign next_blk = held_blk_r + 16'd1;

  // Does the reply fit the opcode that was sent?
  always_comb begin
    case (held_op_r)
      tfrm_pkg::OP_RRQ:  reply_ok = (item.recv_opcode == tfrm_pkg::OP_OACK) ||
                                    (item.recv_opcode == tfrm_pkg::OP_DATA);
      tfrm_pkg::OP_WRQ:  reply_ok = (item.recv_opcode == tfrm_pkg::OP_OACK) ||
                                    (item.recv_opcode == tfrm_pkg::OP_ACK);
      tfrm_pkg::OP_DATA: reply_ok = (item.recv_opcode == tfrm_pkg::OP_ACK) &&
                                    (item.recv_word == held_blk_r);
      tfrm_pkg::OP_ACK:  reply_ok = (item.recv_opcode == tfrm_pkg::OP_DATA) &&
                                    (item.recv_word == next_blk);
      tfrm_pkg::OP_OACK: reply_ok = ((item.recv_opcode == tfrm_pkg::OP_ACK) &&
                                     (item.recv_word == 16'd0)) ||
                                    (item.recv_opcode == tfrm_pkg::OP_DATA);
      default:           reply_ok = 1'b0;
    endcase
  end

  // Retry count after one more expiry, saturating.
  assign retry_inc = (retry_r == tfrm_pkg::RETRY_MAX) ? retry_r : retry_r + 8'd1;

  // Next state and status for the item at the head of the pipeline.
  always_comb begin
    awaiting_nxt = awaiting_r;
    held_op_nxt  = held_op_r;
    held_blk_nxt = held_blk_r;
    retry_nxt    = retry_r;
    timer_nxt    = timer_r;
    status       = tfrm_pkg::ST_WAIT;
    unique case (item.cmd)
      tfrm_pkg::CMD_START: begin
        held_op_nxt  = item.sent_opcode;
        held_blk_nxt = item.sent_block;
        retry_nxt    = 8'd0;
        if (item.last_packet) begin
          awaiting_nxt = 1'b0;
          status       = tfrm_pkg::ST_OK;
        end else begin
          awaiting_nxt = 1'b1;
          timer_nxt    = load_val;
        end
      end
      tfrm_pkg::CMD_TICK: begin
        if (awaiting_r) begin
          if (timer_r > tfrm_pkg::timer_t'(1)) begin
            timer_nxt = timer_r - tfrm_pkg::timer_t'(1);
          end else begin
            retry_nxt = retry_inc;
            if (retry_inc >= cfg.max_retries) begin
              timer_nxt    = '0;
              awaiting_nxt = 1'b0;
              status       = tfrm_pkg::ST_GAVE_UP;
            end else begin
              timer_nxt = load_val;
              status    = tfrm_pkg::ST_RETX;
            end
          end
        end
      end
      tfrm_pkg::CMD_RECV: begin
        if (awaiting_r && !oversize) begin
          if (item.recv_opcode == tfrm_pkg::OP_ERROR) begin
            awaiting_nxt = 1'b0;
            status = (item.recv_word == tfrm_pkg::ERR_UNKNOWN_TID) ?
                     tfrm_pkg::ST_OK : tfrm_pkg::ST_PEER_ERR;
          end else if (reply_ok) begin
            awaiting_nxt = 1'b0;
            status       = tfrm_pkg::ST_OK;
          end
        end
      end
      tfrm_pkg::CMD_SEND_FAIL: begin
        awaiting_nxt = 1'b0;
        status       = tfrm_pkg::ST_SEND_ERR;
      end
      tfrm_pkg::CMD_RECV_FAIL: begin
        if (awaiting_r && item.conn_reset) begin
          awaiting_nxt = 1'b0;
          status       = tfrm_pkg::ST_NO_CONN;
        end
      end
      tfrm_pkg::CMD_WAIT_ERR: begin
        awaiting_nxt = 1'b0;
        status       = tfrm_pkg::ST_WAIT_ERR;
      end
      default: ;
    endcase
  end

  // State moves only when the item is handed to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      held_op_r  <= '0;
      held_blk_r <= '0;
      retry_r    <= '0;
      timer_r    <= '0;
    end else if (advance) begin
      awaiting_r <= awaiting_nxt;
      held_op_r  <= held_op_nxt;
      held_blk_r <= held_blk_nxt;
      retry_r    <= retry_nxt;
      timer_r    <= timer_nxt;
    end
  end

  assign result.status       = status;
  assign result.retries_used = retry_nxt;

endmodule

`default_nettype wire

### src/tftp_reply_matcher_retransmit.sv
// Top level of the TFTP reply matcher with retransmit timer.
// Depends on tfrm_pkg, tfrm_in_if, tfrm_out_if, tfrm_cfg and tfrm_core.
//
// Usage:
//   in_chan carries events and received packet headers (start, tick, packet
//   received, send failed, receive failed, wait error). out_chan returns
//   exactly one status and retry count for every input transfer, in order.
//   The cfg_ port writes max_retries, timeout_ticks and block_size; write
//   it only while no item is in flight.
// Path: an accepted item is held in the input register, evaluated from
//   there, and its result is stored in the result register, from which the
//   receiver takes it.
// Throughput: one item per cycle while out_chan is ready; the input register
//   directly feeds the state update and result register, which advance together.
// Reset: rst_n (synchronous) empties both registers, clears the exchange
//   state and loads the configuration defaults.
// Stall: while out_chan is held, the result register holds its item and the
//   input register can still take one more item; in_chan.ready drops only
//   when both are full.
`default_nettype none

module tftp_reply_matcher_retransmit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tfrm_in_if.sink                              in_chan,
  tfrm_out_if.source                           out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [tfrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tfrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tfrm_pkg::cfg_t    cfg;
  tfrm_pkg::item_t   item_r;
  tfrm_pkg::result_t res;
  tfrm_pkg::result_t res_r;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_xfer;

  tfrm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The head item moves on when the result register is free or being drained.
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.cmd         <= in_chan.cmd;
      item_r.sent_opcode <= in_chan.sent_opcode;
      item_r.sent_block  <= in_chan.sent_block;
      item_r.last_packet <= in_chan.last_packet;
      item_r.recv_length <= in_chan.recv_length;
      item_r.recv_opcode <= in_chan.recv_opcode;
      item_r.recv_word   <= in_chan.recv_word;
      item_r.conn_reset  <= in_chan.conn_reset;
    end
  end

  tfrm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = res_r.status;
  assign out_chan.retries_used = res_r.retries_used;

  // A retransmit always follows at least one counted timeout.
  a_retx_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.status == tfrm_pkg::ST_RETX)) |-> (res_r.retries_used != 8'd0))
    else $error("retransmit reported with zero retries");

  // Input back-pressure only when both registers are full and the output stalls.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (in_valid_r && out_valid_r && !out_chan.ready))
    else $error("input stalled without a full pipeline");

  // An evaluated item always lands in the result register.
  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("evaluated item lost before the result register");

endmodule

`default_nettype wire

### dv/tfrm_reply_checker.sv
// Scoreboard for the TFTP reply matcher: watches both channels and the config port.
// It predicts each status and retry count, then compares them with the block's output.
// Depends on tfrm_pkg and the channel interfaces in tfrm_if.
`default_nettype none

module tfrm_reply_checker
  import tfrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tfrm_in_if                         in_mon,
  tfrm_out_if                        out_mon,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         outstanding
);

  // Shadow copy of the configuration registers.
  logic [7:0]  lim_retries;
  logic [31:0] lim_ticks;
  logic [15:0] lim_bsize;

  // Shadow copy of the exchange state.
  logic        reply_pending;
  logic [15:0] open_op;
  logic [15:0] open_blk;
  logic [7:0]  timeouts;
  timer_t      ticks_left;

  // Predicted results, oldest first.
  result_t expected_replies[$];

  // Timer load value, clamped to what the timer can hold.
  function automatic timer_t reload_value();
    logic [63:0] wide;
    wide = 64'(lim_ticks);
    if (wide > TIMER_MAX64) wide = TIMER_MAX64;
    return timer_t'(wide);
  endfunction

  // Reply acceptance rules keyed by the opcode that was sent.
  function automatic logic reply_accepted(input logic [15:0] op, input logic [15:0] word);
    logic [15:0] next_blk;
    next_blk = open_blk + 16'd1;
    case (open_op)
      OP_RRQ:  return op == OP_OACK || op == OP_DATA;
      OP_WRQ:  return op == OP_OACK || op == OP_ACK;
      OP_DATA: return op == OP_ACK && word == open_blk;
      OP_ACK:  return op == OP_DATA && word == next_blk;
      OP_OACK: return (op == OP_ACK && word == 16'd0) || op == OP_DATA;
      default: return 1'b0;
    endcase
  endfunction

  // Advances the shadow state by one transfer and returns the expected result.
  function automatic result_t predict_reply_status(input item_t it);
    result_t r;
    r.status = ST_WAIT;
    case (it.cmd)
      CMD_START: begin
        open_op  = it.sent_opcode;
        open_blk = it.sent_block;
        timeouts = '0;
        if (it.last_packet) begin
          reply_pending = 1'b0;
          r.status = ST_OK;
        end else begin
          reply_pending = 1'b1;
          ticks_left = reload_value();
        end
      end
      CMD_TICK: begin
        if (reply_pending) begin
          if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
          end else begin
            ticks_left = '0;
            if (timeouts < RETRY_MAX) timeouts++;
            if (timeouts >= lim_retries) begin
              reply_pending = 1'b0;
              r.status = ST_GAVE_UP;
            end else begin
              ticks_left = reload_value();
              r.status = ST_RETX;
            end
          end
        end
      end
      CMD_RECV: begin
        // Oversized packets are dropped before any header check.
        if (reply_pending && 17'(it.recv_length) <= 17'(lim_bsize) + HDR_BYTES) begin
          if (it.recv_opcode == OP_ERROR) begin
            reply_pending = 1'b0;
            r.status = (it.recv_word == ERR_UNKNOWN_TID) ? ST_OK : ST_PEER_ERR;
          end else if (reply_accepted(it.recv_opcode, it.recv_word)) begin
            reply_pending = 1'b0;
            r.status = ST_OK;
          end
        end
      end
      CMD_SEND_FAIL: begin
        reply_pending = 1'b0;
        r.status = ST_SEND_ERR;
      end
      CMD_RECV_FAIL: begin
        if (reply_pending && it.conn_reset) begin
          reply_pending = 1'b0;
          r.status = ST_NO_CONN;
        end
      end
      CMD_WAIT_ERR: begin
        reply_pending = 1'b0;
        r.status = ST_WAIT_ERR;
      end
      default: ;
    endcase
    r.retries_used = timeouts;
    return r;
  endfunction

  // Counts a failure and reports the first ten of them.
  task automatic note_mismatch(input string what, input logic known, input result_t want,
                               input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (known)
        $display("mismatch in %s: expected status %0d retries %0d, got status %0d retries %0d",
                 what, want.status, want.retries_used, got.status, got.retries_used);
      else
        $display("mismatch: %s, got status %0d retries %0d",
                 what, got.status, got.retries_used);
    end
  endtask

  // Everything is sampled at the rising edge; stimulus moves on the falling edge.
  always @(posedge clk) begin
    item_t   seen;
    result_t want;
    result_t got;
    if (!rst_n) begin
      lim_retries   = MAX_RETRIES_RST;
      lim_ticks     = TIMEOUT_TICKS_RST;
      lim_bsize     = BLOCK_SIZE_RST;
      reply_pending = 1'b0;
      open_op       = '0;
      open_blk      = '0;
      timeouts      = '0;
      ticks_left    = '0;
      mismatches    = 0;
      expected_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_RETRIES:   lim_retries = cfg_wdata[7:0];
          REG_TIMEOUT_TICKS: lim_ticks   = cfg_wdata[31:0];
          REG_BLOCK_SIZE:    lim_bsize   = cfg_wdata[15:0];
          default: ;
        endcase
      end

      // A result transfer always belongs to an item taken at an earlier edge.
      if (out_mon.valid && out_mon.ready) begin
        got.status       = out_mon.status;
        got.retries_used = out_mon.retries_used;
        if (expected_replies.size() == 0) begin
          note_mismatch("result with nothing expected", 1'b0, got, got);
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) note_mismatch("status", 1'b1, want, got);
          if (got.retries_used !== want.retries_used)
            note_mismatch("retries_used", 1'b1, want, got);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        seen.cmd         = in_mon.cmd;
        seen.sent_opcode = in_mon.sent_opcode;
        seen.sent_block  = in_mon.sent_block;
        seen.last_packet = in_mon.last_packet;
        seen.recv_length = in_mon.recv_length;
        seen.recv_opcode = in_mon.recv_opcode;
        seen.recv_word   = in_mon.recv_word;
        seen.conn_reset  = in_mon.conn_reset;
        expected_replies.push_back(predict_reply_status(seen));
      end
    end
    outstanding = expected_replies.size();
  end

endmodule

`default_nettype wire

### dv/tftp_reply_matcher_retransmit_tb.sv
// Top of the reply matcher testbench: clock, reset, stimulus, receiver and verdict.
// Depends on tfrm_pkg, the channel interfaces, the block and tfrm_reply_checker.
`default_nettype none

module tftp_reply_matcher_retransmit_tb;
  import tfrm_pkg::*;

  // Command codes that the block has no use for.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    outstanding;

  // Stimulus controls: calm turns idling off, hold_req asks the receiver to hold off.
  bit          calm;
  int          hold_req;
  int          items_sent;
  logic [15:0] cur_bsize;

  tfrm_in_if  in_chan();
  tfrm_out_if out_chan();

  tftp_reply_matcher_retransmit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tfrm_reply_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random hold-offs, plus one long stall counted here on request.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_chan.ready <= 1'b0;
        for (int n = 1; n < hold_req; n++) @(negedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 99) < 10) begin
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  function automatic item_t make_item(input logic [2:0] c, input logic [15:0] s_op,
                                      input logic [15:0] s_blk, input logic last,
                                      input logic [15:0] len, input logic [15:0] r_op,
                                      input logic [15:0] r_word, input logic creset);
    item_t it;
    it.cmd         = c;
    it.sent_opcode = s_op;
    it.sent_block  = s_blk;
    it.last_packet = last;
    it.recv_length = len;
    it.recv_opcode = r_op;
    it.recv_word   = r_word;
    it.conn_reset  = creset;
    return it;
  endfunction

  function automatic item_t random_item();
    return make_item(3'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  // Sent opcodes are mostly the legal ones, sometimes anything.
  function automatic logic [15:0] pick_sent_op();
    case ($urandom_range(0, 5))
      0:       return OP_RRQ;
      1:       return OP_WRQ;
      2:       return OP_DATA;
      3:       return OP_ACK;
      4:       return OP_OACK;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_reply_op();
    case ($urandom_range(0, 4))
      0:       return OP_DATA;
      1:       return OP_ACK;
      2:       return OP_ERROR;
      3:       return OP_OACK;
      default: return 16'($urandom);
    endcase
  endfunction

  // Reply words cluster on the values that the matching rules look at.
  function automatic logic [15:0] pick_reply_word(input logic [15:0] blk);
    case ($urandom_range(0, 4))
      0:       return blk;
      1:       return blk + 16'd1;
      2:       return 16'd0;
      3:       return ERR_UNKNOWN_TID;
      default: return 16'($urandom);
    endcase
  endfunction

  // Lengths are mostly legal, with the boundary and oversized ones mixed in.
  function automatic logic [15:0] pick_length(input logic [15:0] bsize);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(0, 32'(bsize) + 4));
    if (r < 90) return 16'(32'(bsize) + 4 + $urandom_range(0, 1));
    return 16'($urandom);
  endfunction

  // Offers one item and returns on the falling edge after its transfer.
  task automatic send_item(input item_t it);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.cmd         <= it.cmd;
    in_chan.sent_opcode <= it.sent_opcode;
    in_chan.sent_block  <= it.sent_block;
    in_chan.last_packet <= it.last_packet;
    in_chan.recv_length <= it.recv_length;
    in_chan.recv_opcode <= it.recv_opcode;
    in_chan.recv_word   <= it.recv_word;
    in_chan.conn_reset  <= it.conn_reset;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Waits until every expected result has arrived, then rewrites all three registers.
  task automatic apply_settings(input logic [7:0] retries, input logic [31:0] ticks,
                                input logic [15:0] bsize);
    in_chan.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    write_reg(REG_MAX_RETRIES, CFG_DATA_W'(retries));
    write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(ticks));
    write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(bsize));
    cfg_we    <= 1'b0;
    cur_bsize = bsize;
  endtask

  // One exchange: a start followed by one to eight ticks, replies, failures or spare commands.
  task automatic run_exchange();
    item_t       it;
    logic [15:0] blk;
    int          r;
    blk = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
    it = random_item();
    it.cmd         = CMD_START;
    it.sent_opcode = pick_sent_op();
    it.sent_block  = blk;
    it.last_packet = ($urandom_range(0, 9) == 0);
    send_item(it);
    repeat ($urandom_range(1, 8)) begin
      it = random_item();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        it.cmd = CMD_TICK;
      end else if (r < 85) begin
        it.cmd         = CMD_RECV;
        it.recv_opcode = pick_reply_op();
        it.recv_word   = pick_reply_word(blk);
        it.recv_length = pick_length(cur_bsize);
      end else if (r < 90) begin
        it.cmd = CMD_RECV_FAIL;
      end else if (r < 93) begin
        it.cmd = CMD_SEND_FAIL;
      end else if (r < 96) begin
        it.cmd = CMD_WAIT_ERR;
      end else begin
        it.cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
      end
      send_item(it);
    end
  endtask

  // Main stimulus and verdict.
  initial begin
    int phase_end;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.cmd         = '0;
    in_chan.sent_opcode = '0;
    in_chan.sent_block  = '0;
    in_chan.last_packet = 1'b0;
    in_chan.recv_length = '0;
    in_chan.recv_opcode = '0;
    in_chan.recv_word   = '0;
    in_chan.conn_reset  = 1'b0;
    calm       = 1'b0;
    hold_req   = 0;
    items_sent = 0;
    cur_bsize  = BLOCK_SIZE_RST;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset configuration: idle block first.
    send_item(make_item(CMD_TICK, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_RECV, 16'd0, 16'd0, 1'b0, 16'd4, OP_DATA, 16'd0, 1'b0));
    send_item(make_item(CMD_RECV_FAIL, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1));
    // DATA sent: oversized ACK dropped, wrong block ignored, right block accepted.
    send_item(make_item(CMD_START, OP_DATA, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_RECV, 16'd0, 16'd0, 1'b0, 16'd517, OP_ACK, 16'hFFFF, 1'b0));
    send_item(make_item(CMD_RECV, 16'd0, 16'd0, 1'b0, 16'd516, OP_ACK, 16'hFFFE, 1'b0));
    send_item(make_item(CMD_RECV, 16'd0, 16'd0, 1'b0, 16'd516, OP_ACK, 16'hFFFF, 1'b0));
    // ACK sent on the last block number: the next DATA block wraps to zero.
    send_item(make_item(CMD_START, OP_ACK, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_RECV, 16'd0, 16'd0, 1'b0, 16'd0, OP_DATA, 16'd0, 1'b0));
    // Error packets: an unknown transfer ID counts as success, anything else does not.
    send_item(make_item(CMD_START, OP_WRQ, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_RECV, 16'd0, 16'd0, 1'b0, 16'd4, OP_ERROR, 16'hFFFF, 1'b0));
    send_item(make_item(CMD_START, OP_OACK, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_RECV, 16'd0, 16'd0, 1'b0, 16'd4, OP_ACK, 16'd1, 1'b0));
    send_item(make_item(CMD_RECV, 16'd0, 16'd0, 1'b0, 16'd4, OP_ERROR, ERR_UNKNOWN_TID, 1'b0));
    // Unknown sent opcode never matches; a peer reset ends the wait.
    send_item(make_item(CMD_START, 16'hFFFF, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_RECV, 16'd0, 16'd0, 1'b0, 16'd4, OP_DATA, 16'd1, 1'b0));
    send_item(make_item(CMD_RECV_FAIL, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_RECV_FAIL, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1));
    // Last packet, failures and a spare command.
    send_item(make_item(CMD_START, OP_DATA, 16'd9, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_SEND_FAIL, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_WAIT_ERR, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_SPARE_HI, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));

    // Timer runs out twice: one retransmit, then the exchange gives up.
    apply_settings(8'd2, 32'd2, 16'd512);
    send_item(make_item(CMD_START, OP_RRQ, 16'd7, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    repeat (4) send_item(make_item(CMD_TICK, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    // Zero retry limit and zero timeout: the first tick gives up.
    apply_settings(8'd0, 32'd0, 16'd8);
    send_item(make_item(CMD_START, OP_WRQ, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(CMD_TICK, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    // Zero timeout with a limit of two: retransmit on the first tick.
    apply_settings(8'd2, 32'd0, 16'd8);
    send_item(make_item(CMD_START, OP_WRQ, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
    repeat (2) send_item(make_item(CMD_TICK, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));

    // Random phases, each under its own configuration.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: apply_settings(MAX_RETRIES_RST, TIMEOUT_TICKS_RST, BLOCK_SIZE_RST);
        1: apply_settings(8'd3, 32'd4, 16'd512);
        2: apply_settings(8'd1, 32'd1, 16'd8);
        3: apply_settings(8'd0, 32'd0, 16'd100);
        4: apply_settings(8'($urandom_range(1, 8)), 32'($urandom_range(1, 6)),
                          16'($urandom_range(8, 2000)));
        5: apply_settings(8'd2, 32'hFFFF_FFFF, 16'd65464);
        default: apply_settings(8'd255, 32'd1, 16'($urandom_range(8, 65464)));
      endcase
      // Phase one runs with no idling and a long receiver stall up front.
      calm = (ph == 1);
      if (ph == 1) hold_req = 50;
      // With a one-tick timer and the largest limit, run the count all the way up.
      if (ph == 6) begin
        send_item(make_item(CMD_START, OP_WRQ, 16'd1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
        repeat (256)
          send_item(make_item(CMD_TICK, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0));
      end
      phase_end = items_sent + 110;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 12) begin
          repeat ($urandom_range(1, 4)) send_item(random_item());
        end else begin
          run_exchange();
        end
      end
    end
    calm = 1'b0;

    // Drain the remaining results, then allow for the block's latency.
    in_chan.valid <= 1'b0;
    for (int n = 0; n < 10000 && outstanding != 0; n++) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/tfrm_pkg.sv
src/tfrm_if.sv
src/tfrm_cfg.sv
src/tfrm_core.sv
src/tftp_reply_matcher_retransmit.sv
dv/tfrm_reply_checker.sv
dv/tftp_reply_matcher_retransmit_tb.sv
